// ===== hw/rtl/tmm_pkg.sv =====
package tmm_pkg;

  localparam int FIELD_W = 24;
  localparam int NODES = 6;
  localparam int ROW_W = 3;
  localparam int ENTRY_W = 48;
  localparam int DET_W = 51;
  localparam int DMAG_W = 50;
  localparam int SUM_W = 30;
  localparam int SMAG_W = 29;
  localparam int COEF_W = 6;
  localparam int RULES = 21;
  localparam int RULE_W = 5;
  localparam int INPUT_FRAC_BITS_DEF = 16;
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(NODES - 1);

  typedef struct packed {
    logic signed [FIELD_W-1:0] x_corner_0;
    logic signed [FIELD_W-1:0] y_corner_0;
    logic signed [FIELD_W-1:0] x_corner_1;
    logic signed [FIELD_W-1:0] y_corner_1;
    logic signed [FIELD_W-1:0] x_corner_2;
    logic signed [FIELD_W-1:0] y_corner_2;
    logic signed [FIELD_W-1:0] coef_node_0;
    logic signed [FIELD_W-1:0] coef_node_1;
    logic signed [FIELD_W-1:0] coef_node_2;
    logic signed [FIELD_W-1:0] coef_node_3;
    logic signed [FIELD_W-1:0] coef_node_4;
    logic signed [FIELD_W-1:0] coef_node_5;
  } in_t;

  typedef struct packed {
    logic [ROW_W-1:0] row_index;
    logic signed [ENTRY_W-1:0] entry_0;
    logic signed [ENTRY_W-1:0] entry_1;
    logic signed [ENTRY_W-1:0] entry_2;
    logic signed [ENTRY_W-1:0] entry_3;
    logic signed [ENTRY_W-1:0] entry_4;
    logic signed [ENTRY_W-1:0] entry_5;
    logic last_row;
  } out_t;

  // element handed from front to back: determinant plus raw coefficients
  typedef struct packed {
    logic signed [DET_W-1:0] det;
    logic [NODES-1:0][FIELD_W-1:0] coef;
  } mid_t;

  // upper triangle, row by row; divisor code k means 315 * 2^k
  localparam logic signed [COEF_W-1:0] RULE_C [RULES][NODES] = '{
    '{ 6'sd9, -6'sd1, -6'sd1,  6'sd2,  6'sd6,  6'sd6},
    '{-6'sd2, -6'sd2,  6'sd1,  6'sd0,  6'sd0, -6'sd4},
    '{-6'sd2,  6'sd1, -6'sd2,  6'sd0, -6'sd4,  6'sd0},
    '{ 6'sd1,  6'sd0,  6'sd0, -6'sd4, -6'sd2, -6'sd2},
    '{ 6'sd3,  6'sd0, -6'sd1, -6'sd2,  6'sd0,  6'sd0},
    '{ 6'sd3, -6'sd1,  6'sd0, -6'sd2,  6'sd0,  6'sd0},
    '{-6'sd1,  6'sd9, -6'sd1,  6'sd6,  6'sd2,  6'sd6},
    '{ 6'sd1, -6'sd2, -6'sd2, -6'sd4,  6'sd0,  6'sd0},
    '{ 6'sd0,  6'sd3, -6'sd1,  6'sd0, -6'sd2,  6'sd0},
    '{ 6'sd0,  6'sd1,  6'sd0, -6'sd2, -6'sd4, -6'sd2},
    '{-6'sd1,  6'sd3,  6'sd0,  6'sd0, -6'sd2,  6'sd0},
    '{-6'sd1, -6'sd1,  6'sd9,  6'sd6,  6'sd6,  6'sd2},
    '{ 6'sd0, -6'sd1,  6'sd3,  6'sd0,  6'sd0, -6'sd2},
    '{-6'sd1,  6'sd0,  6'sd3,  6'sd0,  6'sd0, -6'sd2},
    '{ 6'sd0,  6'sd0,  6'sd1, -6'sd2, -6'sd2, -6'sd4},
    '{-6'sd2,  6'sd0,  6'sd0,  6'sd18, 6'sd6,  6'sd6},
    '{-6'sd2, -6'sd2,  6'sd0,  6'sd12, 6'sd12, 6'sd8},
    '{-6'sd2,  6'sd0, -6'sd2,  6'sd12, 6'sd8,  6'sd12},
    '{ 6'sd0, -6'sd2,  6'sd0,  6'sd6,  6'sd18, 6'sd6},
    '{ 6'sd0, -6'sd2, -6'sd2,  6'sd8,  6'sd12, 6'sd12},
    '{ 6'sd0,  6'sd0, -6'sd2,  6'sd6,  6'sd6,  6'sd18}
  };

  localparam logic [1:0] RULE_K [RULES] = '{
    2'd2, 2'd3, 2'd3, 2'd1, 2'd1, 2'd1, 2'd2, 2'd3, 2'd1, 2'd1, 2'd1,
    2'd2, 2'd1, 2'd1, 2'd1, 2'd0, 2'd1, 2'd1, 2'd0, 2'd1, 2'd0
  };

  localparam logic [RULE_W-1:0] RULE_OF [NODES][NODES] = '{
    '{5'd0, 5'd1,  5'd2,  5'd3,  5'd4,  5'd5},
    '{5'd1, 5'd6,  5'd7,  5'd8,  5'd9,  5'd10},
    '{5'd2, 5'd7,  5'd11, 5'd12, 5'd13, 5'd14},
    '{5'd3, 5'd8,  5'd12, 5'd15, 5'd16, 5'd17},
    '{5'd4, 5'd9,  5'd13, 5'd16, 5'd18, 5'd19},
    '{5'd5, 5'd10, 5'd14, 5'd17, 5'd19, 5'd20}
  };

endpackage

// ===== hw/rtl/tmm_fifo.sv =====
module tmm_fifo #(
  parameter type T = logic,
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  T     wdata,
  output logic full,
  input  logic pop,
  output T     rdata,
  output logic empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  T mem [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] cnt;
  logic do_wr;
  logic do_rd;

  assign full = (cnt == CW'(DEPTH));
  assign empty = (cnt == '0);
  assign do_wr = push && !full;
  assign do_rd = pop && !empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt <= cnt + 1'b1;
      end else if (!do_wr && do_rd) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/tmm_front.sv =====
module tmm_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tmm_pkg::in_t    item,
  output logic            full,
  output logic            qpush,
  output tmm_pkg::mid_t   qdata,
  input  logic            qfull
);

  localparam int DW = tmm_pkg::FIELD_W + 1;
  localparam int PW = 2 * DW;

  logic adv;
  logic v1;
  logic v2;
  logic signed [DW-1:0] dx1, dy1, dx2, dy2;
  logic signed [PW-1:0] p1, p2;
  logic [tmm_pkg::NODES-1:0][tmm_pkg::FIELD_W-1:0] coef1, coef2;

  assign adv = !(v2 && qfull);
  assign full = !adv;
  assign qpush = v2 && !qfull;
  assign qdata.det = tmm_pkg::DET_W'(p1) - tmm_pkg::DET_W'(p2);
  assign qdata.coef = coef2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (adv) begin
      v1 <= push;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx1 <= DW'(item.x_corner_1) - DW'(item.x_corner_0);
      dy1 <= DW'(item.y_corner_1) - DW'(item.y_corner_0);
      dx2 <= DW'(item.x_corner_2) - DW'(item.x_corner_0);
      dy2 <= DW'(item.y_corner_2) - DW'(item.y_corner_0);
      coef1 <= {item.coef_node_5, item.coef_node_4, item.coef_node_3,
                item.coef_node_2, item.coef_node_1, item.coef_node_0};
      p1 <= PW'(dx1) * PW'(dy2);
      p2 <= PW'(dy1) * PW'(dx2);
      coef2 <= coef1;
    end
  end

endmodule

// ===== hw/rtl/tmm_back.sv =====
module tmm_back #(
  parameter int INPUT_FRAC_BITS = tmm_pkg::INPUT_FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  tmm_pkg::mid_t qdata,
  input  logic          qempty,
  output logic          qpop,
  output logic          opush,
  output tmm_pkg::out_t odata,
  input  logic          ofull
);

  localparam int N = tmm_pkg::NODES;
  localparam int HW = 25;
  localparam int PL_W = HW + tmm_pkg::SMAG_W;
  localparam int P_W = tmm_pkg::DMAG_W + tmm_pkg::SMAG_W;
  localparam int T_W = P_W + 11;
  localparam int TC_W = 58;
  localparam int TL_W = 29;
  localparam int ML_W = 30;
  localparam int M_W = 59;
  localparam int PP_W = 59;
  localparam int RP_W = TC_W + M_W;
  localparam int RS = 68;
  localparam int Q_W = 49;
  localparam int SH = 3 * INPUT_FRAC_BITS - 32;
  localparam int POS0 = (SH + 0 > 0) ? SH + 0 : 0;
  localparam int POS1 = (SH + 1 > 0) ? SH + 1 : 0;
  localparam int POS2 = (SH + 2 > 0) ? SH + 2 : 0;
  localparam int POS3 = (SH + 3 > 0) ? SH + 3 : 0;
  localparam int NEG0 = (SH + 0 < 0) ? -(SH + 0) : 0;
  localparam int NEG1 = (SH + 1 < 0) ? -(SH + 1) : 0;
  localparam int NEG2 = (SH + 2 < 0) ? -(SH + 2) : 0;
  localparam int NEG3 = (SH + 3 < 0) ? -(SH + 3) : 0;
  localparam logic [T_W-1:0] HALF_D = T_W'(315);
  localparam logic [T_W-1:0] T_LIM = T_W'(630) << 48;
  // ceil(2^68 / 630): exact floor(T / 630) for any T below 2^58
  localparam logic [RP_W-1:0] RECIP_FULL = ((RP_W'(1) << RS) + RP_W'(629)) / RP_W'(630);
  localparam logic [M_W-1:0] RECIP = RECIP_FULL[M_W-1:0];
  localparam logic signed [tmm_pkg::ENTRY_W-1:0] E_MAX = {1'b0, {(tmm_pkg::ENTRY_W-1){1'b1}}};
  localparam logic signed [tmm_pkg::ENTRY_W-1:0] E_MIN = {1'b1, {(tmm_pkg::ENTRY_W-1){1'b0}}};

  logic adv;

  // row sequencer
  logic cur_v;
  logic [tmm_pkg::ROW_W-1:0] row;
  logic [tmm_pkg::DMAG_W-1:0] cur_dmag;
  logic cur_dneg;
  logic [N-1:0][tmm_pkg::FIELD_W-1:0] cur_coef;
  logic load;
  logic [tmm_pkg::DET_W-1:0] det_abs;

  // shared stage tags
  logic b1_v, b2_v, b3_v, b4_v, b5_v, m0_v, m1_v, m2_v, f_v;
  logic [tmm_pkg::ROW_W-1:0] b1_row, b2_row, b3_row, b4_row, b5_row;
  logic [tmm_pkg::ROW_W-1:0] m0_row, m1_row, m2_row, f_row;
  logic [tmm_pkg::DMAG_W-1:0] b1_dmag, b2_dmag;
  logic b1_dneg;

  // lanes, one per column
  logic signed [tmm_pkg::SUM_W-1:0] b1_sum [N];
  logic [1:0] b1_k [N];
  logic [1:0] b2_k [N];
  logic [1:0] b3_k [N];
  logic [1:0] b4_k [N];
  logic [tmm_pkg::SMAG_W-1:0] b2_smag [N];
  logic b2_neg [N];
  logic b3_neg [N];
  logic b4_neg [N];
  logic b5_neg [N];
  logic [PL_W-1:0] b3_pl [N];
  logic [PL_W-1:0] b3_ph [N];
  logic [P_W-1:0] b4_p [N];
  logic [T_W-1:0] b5_t [N];
  logic [TC_W-1:0] m0_t [N];
  logic m0_neg [N];
  logic [PP_W-1:0] m1_ll [N];
  logic [PP_W-1:0] m1_lh [N];
  logic [PP_W-1:0] m1_hl [N];
  logic [PP_W-1:0] m1_hh [N];
  logic m1_neg [N];
  logic [Q_W-1:0] m2_q [N];
  logic m2_neg [N];
  logic signed [tmm_pkg::ENTRY_W-1:0] f_ent [N];

  assign adv = !(f_v && ofull);
  assign opush = f_v && !ofull;
  assign load = adv && !qempty && (!cur_v || row == tmm_pkg::LAST_ROW);
  assign qpop = load;
  assign det_abs = qdata.det[tmm_pkg::DET_W-1] ? -qdata.det : qdata.det;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_v <= 1'b0;
      row <= '0;
    end else if (adv) begin
      if (cur_v && row != tmm_pkg::LAST_ROW) begin
        row <= row + 1'b1;
      end else if (!qempty) begin
        cur_v <= 1'b1;
        row <= '0;
      end else begin
        cur_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_dmag <= det_abs[tmm_pkg::DMAG_W-1:0];
      cur_dneg <= qdata.det[tmm_pkg::DET_W-1];
      cur_coef <= qdata.coef;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v <= 1'b0;
      b2_v <= 1'b0;
      b3_v <= 1'b0;
      b4_v <= 1'b0;
      b5_v <= 1'b0;
      m0_v <= 1'b0;
      m1_v <= 1'b0;
      m2_v <= 1'b0;
      f_v <= 1'b0;
    end else if (adv) begin
      b1_v <= cur_v;
      b2_v <= b1_v;
      b3_v <= b2_v;
      b4_v <= b3_v;
      b5_v <= b4_v;
      m0_v <= b5_v;
      m1_v <= m0_v;
      m2_v <= m1_v;
      f_v <= m2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_row <= row;
      b1_dmag <= cur_dmag;
      b1_dneg <= cur_dneg;
      b2_row <= b1_row;
      b2_dmag <= b1_dmag;
      b3_row <= b2_row;
      b4_row <= b3_row;
      b5_row <= b4_row;
      m0_row <= b5_row;
      m1_row <= m0_row;
      m2_row <= m1_row;
      f_row <= m2_row;
    end
  end

  for (genvar c = 0; c < N; c++) begin : g_lane
    localparam int RULE_IDX_W = tmm_pkg::RULE_W;
    logic signed [tmm_pkg::SUM_W-1:0] sum;
    logic [RULE_IDX_W-1:0] rule;
    logic [T_W-1:0] w;
    logic [T_W-1:0] t;
    logic [RP_W-1:0] prod;
    logic [Q_W-1:0] q;

    assign rule = tmm_pkg::RULE_OF[row][c];
    assign w = T_W'({b4_p[c], 1'b0});
    assign prod = RP_W'(m1_ll[c]) + (RP_W'(m1_lh[c]) << ML_W)
                + (RP_W'(m1_hl[c]) << TL_W) + (RP_W'(m1_hh[c]) << (TL_W + ML_W));
    assign q = m2_q[c];

    always_comb begin
      sum = '0;
      for (int k = 0; k < N; k++) begin
        sum = sum + tmm_pkg::SUM_W'(tmm_pkg::RULE_C[rule][k])
                  * tmm_pkg::SUM_W'($signed(cur_coef[k]));
      end
    end

    // T = (2P + d) / 2^s for s >= 0, else 2P * 2^-s + 315; then q = T / 630
    always_comb begin
      case (b4_k[c])
        2'd0: t = ((w << NEG0) + (HALF_D << POS0)) >> POS0;
        2'd1: t = ((w << NEG1) + (HALF_D << POS1)) >> POS1;
        2'd2: t = ((w << NEG2) + (HALF_D << POS2)) >> POS2;
        2'd3: t = ((w << NEG3) + (HALF_D << POS3)) >> POS3;
        default: t = '0;
      endcase
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        b1_sum[c] <= sum;
        b1_k[c] <= tmm_pkg::RULE_K[rule];
        b2_smag[c] <= b1_sum[c][tmm_pkg::SUM_W-1] ? tmm_pkg::SMAG_W'(-b1_sum[c])
                                                  : tmm_pkg::SMAG_W'(b1_sum[c]);
        b2_neg[c] <= b1_dneg ^ b1_sum[c][tmm_pkg::SUM_W-1];
        b2_k[c] <= b1_k[c];
        b3_pl[c] <= PL_W'(b2_dmag[HW-1:0]) * PL_W'(b2_smag[c]);
        b3_ph[c] <= PL_W'(b2_dmag[tmm_pkg::DMAG_W-1:HW]) * PL_W'(b2_smag[c]);
        b3_neg[c] <= b2_neg[c];
        b3_k[c] <= b2_k[c];
        b4_p[c] <= (P_W'(b3_ph[c]) << HW) + P_W'(b3_pl[c]);
        b4_neg[c] <= b3_neg[c];
        b4_k[c] <= b3_k[c];
        b5_t[c] <= t;
        b5_neg[c] <= b4_neg[c];
        // anything at or above 2^48 quotients saturates anyway
        m0_t[c] <= (b5_t[c] >= T_LIM) ? T_LIM[TC_W-1:0] : b5_t[c][TC_W-1:0];
        m0_neg[c] <= b5_neg[c];
        // reciprocal product split into four partial products
        m1_ll[c] <= PP_W'(m0_t[c][TL_W-1:0]) * PP_W'(RECIP[ML_W-1:0]);
        m1_lh[c] <= PP_W'(m0_t[c][TL_W-1:0]) * PP_W'(RECIP[M_W-1:ML_W]);
        m1_hl[c] <= PP_W'(m0_t[c][TC_W-1:TL_W]) * PP_W'(RECIP[ML_W-1:0]);
        m1_hh[c] <= PP_W'(m0_t[c][TC_W-1:TL_W]) * PP_W'(RECIP[M_W-1:ML_W]);
        m1_neg[c] <= m0_neg[c];
        m2_q[c] <= prod[RP_W-1:RS];
        m2_neg[c] <= m1_neg[c];
        if (!m2_neg[c]) begin
          f_ent[c] <= (q[Q_W-1] || q[Q_W-2]) ? E_MAX : $signed(q[tmm_pkg::ENTRY_W-1:0]);
        end else if (q[Q_W-1] || (q[Q_W-2] && |q[Q_W-3:0])) begin
          f_ent[c] <= E_MIN;
        end else begin
          f_ent[c] <= -$signed(q[tmm_pkg::ENTRY_W-1:0]);
        end
      end
    end
  end

  always_comb begin
    odata.row_index = f_row;
    odata.entry_0 = f_ent[0];
    odata.entry_1 = f_ent[1];
    odata.entry_2 = f_ent[2];
    odata.entry_3 = f_ent[3];
    odata.entry_4 = f_ent[4];
    odata.entry_5 = f_ent[5];
    odata.last_row = (f_row == tmm_pkg::LAST_ROW);
  end

endmodule

// ===== hw/rtl/p2_triangle_reaction_mass_matrix.sv =====
// Path: an accepted element passes the front stages (v1, v2), the element queue,
// the row sequencer, back stages b1-b5, m0-m2 and f, and the result queue.
// Rate: the row sequencer issues one matrix row (six lanes, one per column)
// per cycle while the result queue has room; input accepted every cycle until the
// 4-entry element queue fills.
// Reset: synchronous rst clears all valids, queues and the sequencer; no clearing pass.
module p2_triangle_reaction_mass_matrix #(
  parameter int INPUT_FRAC_BITS = tmm_pkg::INPUT_FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  tmm_pkg::in_t  item,
  output logic          empty,
  input  logic          pop,
  output tmm_pkg::out_t result
);

  logic qpush, qfull, qpop, qempty;
  tmm_pkg::mid_t qwdata, qrdata;
  logic opush, ofull;
  tmm_pkg::out_t owdata;

  tmm_front u_front (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .item  (item),
    .full  (full),
    .qpush (qpush),
    .qdata (qwdata),
    .qfull (qfull)
  );

  tmm_fifo #(.T(tmm_pkg::mid_t), .DEPTH(4)) u_elem_q (
    .clk   (clk),
    .rst   (rst),
    .push  (qpush),
    .wdata (qwdata),
    .full  (qfull),
    .pop   (qpop),
    .rdata (qrdata),
    .empty (qempty)
  );

  tmm_back #(.INPUT_FRAC_BITS(INPUT_FRAC_BITS)) u_back (
    .clk    (clk),
    .rst    (rst),
    .qdata  (qrdata),
    .qempty (qempty),
    .qpop   (qpop),
    .opush  (opush),
    .odata  (owdata),
    .ofull  (ofull)
  );

  tmm_fifo #(.T(tmm_pkg::out_t), .DEPTH(2)) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (opush),
    .wdata (owdata),
    .full  (ofull),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

  a_row_order: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !result.last_row) |=>
      (empty || result.row_index == $past(result.row_index) + 1'b1))
    else $error("rows out of order");

  a_last_row: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.last_row == (result.row_index == tmm_pkg::LAST_ROW)))
    else $error("last_row mismatch");

  a_first_row: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && result.last_row) |=> (empty || result.row_index == '0))
    else $error("element does not start at row 0");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> empty)
    else $error("results present after reset");

endmodule
